@@ src/heap_sort_engine_defines.svh @@
// Assertion macros shared by the heap sort engine RTL
`ifndef HEAP_SORT_ENGINE_DEFINES_SVH
`define HEAP_SORT_ENGINE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define HSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define HSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/hse_pkg.sv @@
// Package: types and constants of the heap sort engine
`timescale 1ns / 1ps
package hse_pkg;

   // number of cells in the sorting chain
   localparam int DEPTH = 64;
   // count width, able to hold DEPTH itself
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef logic signed [31:0] data_type;
   typedef logic [CNT_W-1:0]   cnt_type;

   // control from the sequencer to the cell chain
   typedef struct packed {
      logic    ins;   // broadcast insert of the request word
      logic    shl;   // shift the chain one cell toward the head
      cnt_type cnt;   // number of occupied cells
   } ctl_type;

endpackage

@@ src/hse_req_if.sv @@
// Interface: request channel carrying elements to sort
`timescale 1ns / 1ps
interface hse_req_if;
   import hse_pkg::*;

   logic     valid;
   logic     ready;
   data_type value;
   logic     last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);

endinterface

@@ src/hse_rsp_if.sv @@
// Interface: response channel carrying sorted elements
`timescale 1ns / 1ps
interface hse_rsp_if;
   import hse_pkg::*;

   logic     valid;
   logic     ready;
   data_type sorted_value;
   logic     last_out;
   logic     overflowed;

   modport source (output valid, output sorted_value, output last_out,
                   output overflowed, input ready);
   modport sink   (input valid, input sorted_value, input last_out,
                   input overflowed, output ready);

endinterface

@@ src/hse_cell.sv @@
// One cell of the sorting chain: holds one element, keeps the chain ascending
`timescale 1ns / 1ps
module hse_cell (
   input  logic              clock,
   input  hse_pkg::ctl_type  ctl,
   input  logic              occ,        // this cell holds an element
   input  hse_pkg::data_type new_val,    // broadcast request word
   input  logic              prev_pos,   // insert point lies at or before previous cell
   input  hse_pkg::data_type prev_val,
   input  hse_pkg::data_type next_val,
   output logic              pos,
   output hse_pkg::data_type val
);
   import hse_pkg::*;

   data_type val_ff;
   data_type val_in;

   // new word belongs here or earlier when the cell is empty or holds a larger value
   assign pos = !occ || (new_val < val_ff);
   assign val = val_ff;

   // insert shifts larger elements one cell right; emit shifts everything left
   always_comb begin
      val_in = val_ff;
      if (ctl.ins) begin
         if (prev_pos) begin
            val_in = prev_val;
         end else if (pos) begin
            val_in = new_val;
         end
      end else if (ctl.shl) begin
         val_in = next_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

@@ src/hse_ctrl.sv @@
// Sequencer: counts stored elements, tracks drops and runs the emit phase
`timescale 1ns / 1ps
`include "heap_sort_engine_defines.svh"
module hse_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic             last_out,
   output logic             overflowed,
   output hse_pkg::ctl_type ctl
);
   import hse_pkg::*;

   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic    state_ff, state_in;
   cnt_type cnt_ff, cnt_in;
   logic    drop_ff, drop_in;
   logic    acc, full;

   assign req_ready  = (state_ff == ST_LOAD);
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign acc        = req_valid && req_ready;
   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign last_out   = (cnt_ff == CNT_W'(1));
   assign overflowed = drop_ff;

   assign ctl.ins = acc && !full;
   assign ctl.shl = rsp_valid && rsp_ready;
   assign ctl.cnt = cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      drop_in  = drop_ff;
      case (state_ff)
         ST_LOAD: begin
            if (acc) begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (req_last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (ctl.shl) begin
               cnt_in = cnt_ff - CNT_W'(1);
               if (last_out) begin
                  state_in = ST_LOAD;
                  drop_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         drop_ff  <= drop_in;
      end
   end

   // checks
   `HSE_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(DEPTH),
      "element count exceeds depth")
   `HSE_ASSERT_NOW(a_emit_nonempty, clock, reset, state_ff == ST_EMIT,
      cnt_ff != '0, "emit phase with empty chain")
   `HSE_ASSERT_NEXT(a_last_start, clock, reset, acc && req_last,
      state_ff == ST_EMIT && cnt_ff != '0, "last word did not start emission")
   `HSE_ASSERT_NEXT(a_run_end, clock, reset, ctl.shl && last_out,
      state_ff == ST_LOAD && cnt_ff == '0 && !drop_ff, "run did not end cleanly")

endmodule

@@ src/heap_sort_engine.sv @@
// Top level: sorting engine built from a chain of compare-and-shift cells
//
// Usage: words arrive on req_ch (value, last). Each accepted word is placed
// in the chain at its sorted position as it is accepted, so req_ch takes one word
// per cycle while loading. The word with last set closes the set. From the
// next cycle the block sends the stored elements on rsp_ch in ascending
// order, one per cycle while rsp_ch.ready is high, with last_out on the
// final one and overflowed on all of them when words past the 64-entry
// capacity were dropped (a dropped word marked last still closes the set).
// The load rate is set by the broadcast compare in every cell, which
// resolves the insert point for all cells at once.
// req_ch.ready is low for the whole emit phase.
// Reset: synchronous, clears the count and drop flag; the chain is empty.
// Stall: while rsp_ch.ready is low the chain holds and the head word stays
// on rsp_ch unchanged.
`timescale 1ns / 1ps
module heap_sort_engine (
   input  logic      clock,
   input  logic      reset,
   hse_req_if.sink   req_ch,
   hse_rsp_if.source rsp_ch
);
   import hse_pkg::*;

   ctl_type  ctl;
   logic     pos [DEPTH];
   data_type val [DEPTH];

   hse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_last   (req_ch.last),
      .req_ready  (req_ch.ready),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .last_out   (rsp_ch.last_out),
      .overflowed (rsp_ch.overflowed),
      .ctl        (ctl)
   );

   // cell chain, smallest element at the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic     occ;
      logic     p_pos;
      data_type p_val;
      data_type n_val;

      assign occ = (CNT_W'(i) < ctl.cnt);

      if (i == 0) begin : g_head
         assign p_pos = 1'b0;
         assign p_val = '0;
      end else begin : g_body
         assign p_pos = pos[i-1];
         assign p_val = val[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign n_val = '0;
      end else begin : g_mid
         assign n_val = val[i+1];
      end

      hse_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .occ      (occ),
         .new_val  (req_ch.value),
         .prev_pos (p_pos),
         .prev_val (p_val),
         .next_val (n_val),
         .pos      (pos[i]),
         .val      (val[i])
      );
   end

   assign rsp_ch.sorted_value = val[0];

endmodule

@@ test/tb_heap_sort_engine.sv @@
// Testbench: heap_sort_engine checked against an insertion-sort predictor
`timescale 1ns / 1ps
module tb_heap_sort_engine;
   import hse_pkg::*;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int SHOWN_FAULTS  = 10;

   localparam logic [1:0] PH_SLOW_RX = 2'd0;
   localparam logic [1:0] PH_SLOW_TX = 2'd1;
   localparam logic [1:0] PH_FULL    = 2'd2;

   localparam data_type MIN_VAL = data_type'(32'h8000_0000);
   localparam data_type MAX_VAL = data_type'(32'h7fff_ffff);

   // one request word waiting in the stimulus queue
   typedef struct {
      data_type   value;
      logic       last;
      logic       drain;   // wait until every sorted word is back
      logic       hold;    // start a long receiver hold-off
      logic [1:0] phase;
   } req_word_type;

   // one expected sorted word
   typedef struct packed {
      data_type value;
      logic     last_out;
      logic     overflowed;
   } sorted_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hse_req_if req_bus ();
   hse_rsp_if rsp_bus ();

   heap_sort_engine u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   req_word_type    word_q[$];
   sorted_word_type sorted_due[$];
   data_type        set_vals[$];     // current set, kept in ascending order
   logic            set_dropped = 1'b0;
   int              results_due = 0;
   int              fault_cnt   = 0;
   int              cycle_cnt   = 0;
   int              stall_left  = 0;
   logic            hold_kick   = 1'b0;
   logic            stim_done   = 1'b0;
   logic [1:0]      run_phase   = PH_SLOW_RX;

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // idle percentage per phase, for sender or receiver
   function automatic int idle_pct(input logic [1:0] ph, input logic rx_side);
      case (ph)
         PH_SLOW_RX: return rx_side ? 56 : 28;
         PH_SLOW_TX: return rx_side ? 28 : 56;
         default:    return 0;
      endcase
   endfunction

   function automatic data_type pick_value();
      case ($urandom_range(9))
         0:       return MIN_VAL;
         1:       return MAX_VAL;
         2, 3:    return data_type'($urandom_range(8)) - data_type'(4);
         default: return data_type'($urandom);
      endcase
   endfunction

   task automatic push_word(input data_type v, input logic lst, input logic [1:0] ph,
                            input logic drn, input logic hld);
      req_word_type w;
      w.value = v;
      w.last  = lst;
      w.phase = ph;
      w.drain = drn;
      w.hold  = hld;
      word_q.insert(word_q.size(), w);
   endtask

   task automatic add_set(input int n, input logic [1:0] ph, input logic drn,
                          input logic hld);
      for (int i = 0; i < n; i++)
         push_word(pick_value(), i == n - 1, ph, drn && i == 0, hld && i == 0);
   endtask

   task automatic note_fault(input string what, input sorted_word_type want,
                             input sorted_word_type got);
      fault_cnt++;
      if (fault_cnt <= SHOWN_FAULTS)
         $display("%0d: %s: expected value %0d last %b ovf %b, got value %0d last %b ovf %b",
                  cycle_cnt, what, want.value, want.last_out, want.overflowed,
                  got.value, got.last_out, got.overflowed);
   endtask

   // sender: offers queued words, holds each until accepted
   always @(posedge clock) begin : word_driver
      req_word_type nxt;
      logic         offer;
      logic         just_closed;
      logic         kick;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.value <= '0;
         req_bus.last  <= 1'b0;
         hold_kick     <= 1'b0;
      end else begin
         offer       = req_bus.valid;
         just_closed = 1'b0;
         kick        = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            offer       = 1'b0;
            just_closed = req_bus.last;
            if (word_q.size() == 0)
               stim_done <= 1'b1;
         end
         if (!offer && word_q.size() != 0) begin
            nxt = word_q[0];
            if (!(nxt.drain && (results_due != 0 || just_closed)) &&
                $urandom_range(99) >= idle_pct(nxt.phase, 1'b0)) begin
               void'(word_q.pop_front());
               req_bus.value <= nxt.value;
               req_bus.last  <= nxt.last;
               run_phase     <= nxt.phase;
               kick          = nxt.hold;
               offer         = 1'b1;
            end
         end
         req_bus.valid <= offer;
         hold_kick     <= kick;
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin : hold_counter
      if (reset)
         stall_left <= 0;
      else if (hold_kick)
         stall_left <= HOLD_CYCLES;
      else if (stall_left != 0)
         stall_left <= stall_left - 1;
   end

   // receiver: random stalls on top of the hold-off
   always @(posedge clock) begin : result_receiver
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= (stall_left == 0) &&
                          ($urandom_range(99) >= idle_pct(run_phase, 1'b1));
   end

   // predict on accepted request words, check accepted sorted words
   always @(posedge clock) begin : sort_monitor
      sorted_word_type got;
      sorted_word_type want;
      int              pos;
      if (reset) begin
         sorted_due.delete();
         set_vals.delete();
         set_dropped = 1'b0;
         results_due <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            // keep the set sorted as it loads; a full store drops the word
            if (set_vals.size() < DEPTH) begin
               pos = set_vals.size();
               for (int i = 0; i < set_vals.size(); i++) begin
                  if (set_vals[i] > req_bus.value) begin
                     pos = i;
                     break;
                  end
               end
               set_vals.insert(pos, req_bus.value);
            end else begin
               set_dropped = 1'b1;
            end
            // a last word closes the set, even when dropped
            if (req_bus.last) begin
               for (int k = 0; k < set_vals.size(); k++) begin
                  want.value      = set_vals[k];
                  want.last_out   = (k == set_vals.size() - 1);
                  want.overflowed = set_dropped;
                  sorted_due.insert(sorted_due.size(), want);
               end
               set_vals.delete();
               set_dropped = 1'b0;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.value      = rsp_bus.sorted_value;
            got.last_out   = rsp_bus.last_out;
            got.overflowed = rsp_bus.overflowed;
            if (sorted_due.size() == 0) begin
               note_fault("unexpected word", '0, got);
            end else begin
               want = sorted_due.pop_front();
               if (got.value !== want.value || got.last_out !== want.last_out ||
                   got.overflowed !== want.overflowed)
                  note_fault("mismatch", want, got);
            end
         end
         results_due <= sorted_due.size();
      end
   end

   // cycle limit
   always @(posedge clock) begin : watchdog
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      data_type dir_vals[23];
      int       dir_lens[7];
      int       idx;
      int       added;
      int       big;
      int       n;
      dir_vals = '{
         32'sd0,
         MAX_VAL,
         MIN_VAL,
         MAX_VAL, MIN_VAL, -32'sd1, 32'sd0, 32'sd1,
         32'sd5, 32'sd5, 32'sd5,
         32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1, -32'sd2,
         32'sd1, -32'sd1, 32'sd1, -32'sd1, MIN_VAL, MAX_VAL
      };
      dir_lens = '{1, 1, 1, 5, 3, 6, 6};

      // directed sets: single words, extremes, duplicates, reversed order
      idx = 0;
      foreach (dir_lens[s]) begin
         for (int i = 0; i < dir_lens[s]; i++) begin
            push_word(dir_vals[idx], i == dir_lens[s] - 1, PH_SLOW_RX, 1'b0, 1'b0);
            idx++;
         end
      end

      // random sets per phase, each led by a large one near the store depth
      for (int ph = 0; ph < 3; ph++) begin
         big = (ph == 0) ? DEPTH + 1 : (ph == 1) ? DEPTH + 6 : DEPTH;
         add_set(big, ph[1:0], 1'b1, ph == 2);
         added = big;
         while (added < 130) begin
            n = $urandom_range(1, 12);
            if ($urandom_range(15) == 0)
               n = $urandom_range(DEPTH - 4, DEPTH + 2);
            add_set(n, ph[1:0], (added > big + 12) && $urandom_range(5) == 0, 1'b0);
            added += n;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (!stim_done) @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fault_cnt == 0 && sorted_due.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
